// ----- design/tcpq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcpq_pkg: shared types and constants of the two-class priority queue
// operation and status codes, default sizes, and the fifo control structs
// ----------------------------------------------------------------------------
package tcpq_pkg;

  // widths of the identifier ports
  localparam int IdPortBits = 16;

  // default sizes
  localparam int DefDepth  = 16;
  localparam int DefIdBits = 16;

  typedef enum logic {
    FUNC_ENQ = 1'b0,
    FUNC_DEQ = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // per-class fifo command
  typedef struct packed {
    logic push;
    logic pop;
  } fifo_cmd_t;

  // per-class fifo occupancy flags
  typedef struct packed {
    logic empty;
    logic full;
    logic last;   // exactly one entry held
  } fifo_stat_t;

endpackage

// ----- design/tcpq_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcpq_fifo: one priority class of the queue
// circular buffer memory with read and write pointers and an entry count
// ----------------------------------------------------------------------------
module tcpq_fifo #(
  parameter int DEPTH     = tcpq_pkg::DefDepth,
  parameter int DATA_BITS = tcpq_pkg::DefIdBits
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  tcpq_pkg::fifo_cmd_t    cmd_i,
  input  logic [DATA_BITS-1:0]   wdata_i,
  output logic [DATA_BITS-1:0]   rdata_o,
  output tcpq_pkg::fifo_stat_t   stat_o
);
  import tcpq_pkg::*;

  localparam int PtrBits = $clog2(DEPTH);
  localparam int CntBits = $clog2(DEPTH + 1);
  localparam logic [PtrBits-1:0] PtrLast = PtrBits'(DEPTH - 1);
  localparam logic [CntBits-1:0] CntFull = CntBits'(DEPTH);
  localparam logic [CntBits-1:0] CntOne  = CntBits'(1);

  logic [DATA_BITS-1:0] mem [DEPTH];
  logic [DATA_BITS-1:0] rdata_q;
  logic [PtrBits-1:0]   rd_ptr_q, rd_ptr_d;
  logic [PtrBits-1:0]   wr_ptr_q, wr_ptr_d;
  logic [CntBits-1:0]   count_q, count_d;

  // pointers wrap at depth, which need not be a power of two
  always_comb begin
    rd_ptr_d = rd_ptr_q;
    wr_ptr_d = wr_ptr_q;
    count_d  = count_q;
    if (cmd_i.push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PtrBits'(1);
      count_d  = count_q + CntOne;
    end else if (cmd_i.pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrBits'(1);
      count_d  = count_q - CntOne;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      rd_ptr_q <= rd_ptr_d;
      wr_ptr_q <= wr_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      mem[wr_ptr_q] <= wdata_i;
    end
    if (cmd_i.pop) begin
      rdata_q <= mem[rd_ptr_q];
    end
  end

  assign rdata_o      = rdata_q;
  assign stat_o.empty = (count_q == '0);
  assign stat_o.full  = (count_q == CntFull);
  assign stat_o.last  = (count_q == CntOne);

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntFull)
    else $error("fifo count beyond depth");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push |-> (count_q != CntFull) && !cmd_i.pop)
    else $error("push into full fifo or push with pop");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != '0) && (count_q != CntFull) |-> rd_ptr_q != wr_ptr_q)
    else $error("pointers meet while fifo partly filled");

endmodule

// ----- design/two_class_priority_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_class_priority_queue: strict two-level priority fifo
// urgent words are served before normal ones, each class first in, first out
// ----------------------------------------------------------------------------
// A word is taken at every rising edge where start_i is high and busy_o is low;
// busy_o is high only in the first cycle after reset, so one operation is taken
// per clock from then on. Every word yields exactly one result, shown on the
// result ports for a single cycle under done_o. The word passes through the
// input register and then the result register, which raises the strobe. While
// the word sits in the input register, the decision logic
// works on it, and the next edge loads the result register and the class
// memory's registered read port. The receiver
// cannot stall; results are never held. An enqueue into a class that already
// holds DEPTH entries is dropped and reported as full; a dequeue with both
// classes empty is reported as empty. out_id_o and out_urgent_o are zero unless
// a dequeue removed an entry. now_empty_o tells whether both classes are empty
// once the operation has taken effect.
// ----------------------------------------------------------------------------
module two_class_priority_queue #(
  parameter int DEPTH   = tcpq_pkg::DefDepth,
  parameter int ID_BITS = tcpq_pkg::DefIdBits
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic                              func_i,
  input  logic [tcpq_pkg::IdPortBits-1:0]   entry_id_i,
  input  logic                              urgent_i,
  output logic                              done_o,
  output logic [tcpq_pkg::IdPortBits-1:0]   out_id_o,
  output logic                              out_urgent_o,
  output logic [1:0]                        status_o,
  output logic                              now_empty_o
);
  import tcpq_pkg::*;

  // stored identifier width: the port carries at most IdPortBits anyway
  localparam int IdW = (ID_BITS < IdPortBits) ? ID_BITS : IdPortBits;

  // busy for one cycle out of reset
  logic busy_q;

  // input register
  logic                  in_valid_q;
  func_e                 func_q;
  logic [IdPortBits-1:0] id_q;
  logic                  urgent_q;

  // result register
  logic    done_q;
  status_e status_q, status_d;
  logic    out_urgent_q, out_urgent_d;
  logic    popped_q, popped_d;
  logic    now_empty_q, now_empty_d;

  // class fifos
  fifo_cmd_t        urg_cmd, nrm_cmd;
  fifo_stat_t       urg_stat, nrm_stat;
  logic [IdW-1:0]   urg_rdata, nrm_rdata;
  logic [IdW-1:0]   sel_rdata;
  logic             accept;

  assign accept = start_i && !busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b1;
      in_valid_q <= 1'b0;
    end else begin
      busy_q     <= 1'b0;
      in_valid_q <= accept;
    end
  end

  // operand payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q   <= func_e'(func_i);
      id_q     <= entry_id_i;
      urgent_q <= urgent_i;
    end
  end

  // decision: enqueue into the chosen class, or dequeue urgent first
  always_comb begin
    urg_cmd      = '0;
    nrm_cmd      = '0;
    status_d     = ST_OK;
    out_urgent_d = 1'b0;
    popped_d     = 1'b0;
    if (in_valid_q) begin
      case (func_q)
        FUNC_ENQ: begin
          if (urgent_q) begin
            if (urg_stat.full) status_d = ST_FULL;
            else               urg_cmd.push = 1'b1;
          end else begin
            if (nrm_stat.full) status_d = ST_FULL;
            else               nrm_cmd.push = 1'b1;
          end
        end
        FUNC_DEQ: begin
          if (!urg_stat.empty) begin
            urg_cmd.pop  = 1'b1;
            out_urgent_d = 1'b1;
            popped_d     = 1'b1;
          end else if (!nrm_stat.empty) begin
            nrm_cmd.pop = 1'b1;
            popped_d    = 1'b1;
          end else begin
            status_d = ST_EMPTY;
          end
        end
        default: status_d = ST_OK;
      endcase
    end
  end

  // both classes empty after this step
  assign now_empty_d =
    ((urg_stat.empty && !urg_cmd.push) || (urg_stat.last && urg_cmd.pop)) &&
    ((nrm_stat.empty && !nrm_cmd.push) || (nrm_stat.last && nrm_cmd.pop));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q     <= status_d;
    out_urgent_q <= out_urgent_d;
    popped_q     <= popped_d;
    now_empty_q  <= now_empty_d;
  end

  tcpq_fifo #(
    .DEPTH     (DEPTH),
    .DATA_BITS (IdW)
  ) u_urgent_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (urg_cmd),
    .wdata_i (id_q[IdW-1:0]),
    .rdata_o (urg_rdata),
    .stat_o  (urg_stat)
  );

  tcpq_fifo #(
    .DEPTH     (DEPTH),
    .DATA_BITS (IdW)
  ) u_normal_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (nrm_cmd),
    .wdata_i (id_q[IdW-1:0]),
    .rdata_o (nrm_rdata),
    .stat_o  (nrm_stat)
  );

  // read data is registered in the fifo, picked by the class that popped
  assign sel_rdata = out_urgent_q ? urg_rdata : nrm_rdata;

  assign busy_o       = busy_q;
  assign done_o       = done_q;
  assign out_id_o     = popped_q ? IdPortBits'(sel_rdata) : '0;
  assign out_urgent_o = done_q && out_urgent_q;
  assign status_o     = done_q ? status_q : ST_OK;
  assign now_empty_o  = done_q && now_empty_q;

  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q |=> done_q)
    else $error("accepted word produced no result");

  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(in_valid_q))
    else $error("result without accepted word");

  a_one_class: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(urg_cmd.pop && nrm_cmd.pop) && !(urg_cmd.push && nrm_cmd.push))
    else $error("both classes touched in one step");

  a_empty_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o == ST_EMPTY) |-> now_empty_o && !out_urgent_o)
    else $error("empty error while queue holds entries");

  a_full_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o == ST_FULL) |-> !now_empty_o && (out_id_o == '0))
    else $error("full error while queue reports empty");

endmodule
